// ===== hw/rtl/voxel_shell_neighbour_masks_core_assert.svh =====
// Assertion macros for the voxel shell core.
// Depends on nothing; included by the top level.
`ifndef VOXEL_SHELL_NEIGHBOUR_MASKS_CORE_ASSERT_SVH
`define VOXEL_SHELL_NEIGHBOUR_MASKS_CORE_ASSERT_SVH
`ifndef SYNTH
`define VS_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define VS_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`else
`define VS_ASSERT_IMP(lbl, clk, rstn, a, c)
`define VS_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

// ===== hw/rtl/vsnm_pkg.sv =====
// Shared types and codes for the voxel shell core.
// No dependencies.
package vsnm_pkg;
    typedef enum logic [1:0] {
        FN_CLEAR = 2'd0,
        FN_MARK  = 2'd1,
        FN_CLASS = 2'd2,
        FN_QUERY = 2'd3
    } t_func;
    localparam logic [1:0] CLS_INNER   = 2'd0;
    localparam logic [1:0] CLS_SURFACE = 2'd1;
    localparam logic [1:0] CLS_OUTER   = 2'd2;
endpackage

// ===== hw/rtl/vsnm_grid_mem.sv =====
// One grid's class store: synchronous single-port RAM with a registered read.
// Depends on nothing.
module vsnm_grid_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [1:0]    i_wdata,
    output logic [1:0]    o_rdata
);
    logic [1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hw/rtl/voxel_shell_neighbour_masks_core.sv =====
// Voxel shell core: two staggered class grids with clear, mark, classify and query.
// Mark and query stop early when out of range; classify reads each scanned point in ST_SCAN
// and writes it back in ST_SWR.
// One command at a time; busy drops in the strobe cycle, so the next command may be taken
// at the edge that ends it. The strobe o_valid lasts one cycle and cannot be stalled.
// Sync active-low reset clears both grids in a sweep over all n2^3 addresses, busy high, no strobe.
`include "voxel_shell_neighbour_masks_core_assert.svh"
module voxel_shell_neighbour_masks_core #(
    parameter int GRID_WIDTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic       i_grid_sel,
    input  logic [3:0] i_a_x,
    input  logic [3:0] i_a_y,
    input  logic [3:0] i_a_z,
    input  logic [3:0] i_b_x,
    input  logic [3:0] i_b_y,
    input  logic [3:0] i_b_z,
    output logic       o_valid,
    output logic [1:0] o_point_class,
    output logic [5:0] o_same_mask,
    output logic [7:0] o_other_mask,
    output logic       o_is_static,
    output logic       o_error
);
    localparam int N1  = GRID_WIDTH;
    localparam int N2  = GRID_WIDTH + 1;
    localparam int D1  = N1 * N1 * N1;
    localparam int D2  = N2 * N2 * N2;
    localparam int AW1 = $clog2(D1);
    localparam int AW2 = $clog2(D2);
    localparam int CW  = 5;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_MARK  = 7'b0000100,
        ST_QRY   = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_SWR   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    logic [1:0] r_func;
    logic       r_sel;
    logic [CW-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic [4:0] r_step;     // mark: 16 writes; query: 15 reads plus pipe
    logic       r_err;
    logic [1:0] r_cls;
    logic [5:0] r_same;
    logic [7:0] r_other;
    logic [AW2:0] r_clr;
    logic       r_init;     // the sweep after reset gives no result beat
    // scan state
    logic       r_sg;       // grid under scan
    logic [1:0] r_axis;
    logic       r_dir;
    logic [CW-1:0] r_u, r_v, r_t;

    logic          we1, we2;
    logic [AW1-1:0] ad1;
    logic [AW2-1:0] ad2;
    logic [1:0]    wd1, wd2, rd1, rd2;

    vsnm_grid_mem #(.DEPTH(D1), .AW(AW1)) u_g1 (
        .i_clk(i_clk), .i_we(we1), .i_addr(ad1), .i_wdata(wd1), .o_rdata(rd1));
    vsnm_grid_mem #(.DEPTH(D2), .AW(AW2)) u_g2 (
        .i_clk(i_clk), .i_we(we2), .i_addr(ad2), .i_wdata(wd2), .o_rdata(rd2));

    function automatic logic [AW2-1:0] idx(input logic [CW-1:0] n, input logic [CW-1:0] x,
                                           input logic [CW-1:0] y, input logic [CW-1:0] z);
        logic [2*AW2-1:0] t;
        t = ((2*AW2)'(z) * (2*AW2)'(n) + (2*AW2)'(y)) * (2*AW2)'(n) + (2*AW2)'(x);
        return t[AW2-1:0];
    endfunction

    localparam logic [CW-1:0] S1 = CW'(N1);
    localparam logic [CW-1:0] S2 = CW'(N2);

    // query access list: 0 centre, 1..6 same neighbours, 7..14 other corners
    logic [CW-1:0] q_x, q_y, q_z, q_n;
    logic          q_oth;
    logic [CW-1:0] base_x, base_y, base_z;
    always_comb begin
        q_x = r_ax; q_y = r_ay; q_z = r_az; q_oth = 1'b0;
        base_x = r_sel ? r_ax - 1'b1 : r_ax;
        base_y = r_sel ? r_ay - 1'b1 : r_ay;
        base_z = r_sel ? r_az - 1'b1 : r_az;
        case (r_step)
            5'd1: q_x = r_ax - 1'b1;
            5'd2: q_x = r_ax + 1'b1;
            5'd3: q_y = r_ay - 1'b1;
            5'd4: q_y = r_ay + 1'b1;
            5'd5: q_z = r_az - 1'b1;
            5'd6: q_z = r_az + 1'b1;
            default: begin
                if (r_step >= 5'd7 && r_step <= 5'd14) begin
                    q_oth = 1'b1;
                    q_x = base_x + CW'(r_step[0] ^ 1'b1);
                    q_y = base_y + CW'(((r_step - 5'd7) >> 1) & 5'd1);
                    q_z = base_z + CW'(((r_step - 5'd7) >> 2) & 5'd1);
                end
            end
        endcase
        q_n = ((r_sel ^ q_oth) ? S2 : S1);
    end
    logic q_in;
    assign q_in = (q_x < q_n) && (q_y < q_n) && (q_z < q_n);
    logic q_g2;
    assign q_g2 = r_sel ^ q_oth;

    // previous query access, aligned with read data
    logic       r_q_in, r_q_g2, r_q_v;
    logic [4:0] r_q_step;

    // scan point
    logic [CW-1:0] sn, s_pos, s_x, s_y, s_z;
    always_comb begin
        sn = r_sg ? S2 : S1;
        s_pos = r_dir ? sn - 1'b1 - r_t : r_t;
        s_x = s_pos; s_y = r_u; s_z = r_v;
        case (r_axis)
            2'd0: begin s_x = s_pos; s_y = r_u; s_z = r_v; end
            2'd1: begin s_y = s_pos; s_z = r_u; s_x = r_v; end
            default: begin s_z = s_pos; s_x = r_u; s_y = r_v; end
        endcase
    end
    logic [1:0] s_rd;
    assign s_rd = r_sg ? rd2 : rd1;

    // mark corner
    logic [2:0] mc;
    logic       mg2;
    assign mc  = r_step[2:0];
    assign mg2 = r_step[3];

    always_comb begin
        we1 = 1'b0; we2 = 1'b0; wd1 = vsnm_pkg::CLS_INNER; wd2 = vsnm_pkg::CLS_INNER;
        ad1 = '0; ad2 = '0;
        unique case (r_state)
            ST_CLEAR: begin
                we1 = r_clr < (AW2+1)'(D1);
                we2 = r_clr < (AW2+1)'(D2);
                ad1 = r_clr[AW1-1:0];
                ad2 = r_clr[AW2-1:0];
            end
            ST_MARK: begin
                we1 = !r_err && !mg2;
                we2 = !r_err && mg2;
                wd1 = vsnm_pkg::CLS_SURFACE; wd2 = vsnm_pkg::CLS_SURFACE;
                ad1 = AW1'(idx(S1, r_ax + CW'(mc[0]), r_ay + CW'(mc[1]), r_az + CW'(mc[2])));
                ad2 = idx(S2, r_bx + CW'(mc[0]), r_by + CW'(mc[1]), r_bz + CW'(mc[2]));
            end
            ST_QRY: begin
                ad1 = AW1'(idx(S1, q_x, q_y, q_z));
                ad2 = idx(S2, q_x, q_y, q_z);
            end
            ST_SCAN: begin
                ad1 = AW1'(idx(S1, s_x, s_y, s_z));
                ad2 = idx(S2, s_x, s_y, s_z);
            end
            ST_SWR: begin
                // read data is back; write outer unless it is a surface point
                ad1 = AW1'(idx(S1, s_x, s_y, s_z));
                ad2 = idx(S2, s_x, s_y, s_z);
                wd1 = vsnm_pkg::CLS_OUTER; wd2 = vsnm_pkg::CLS_OUTER;
                we1 = !r_sg && (s_rd != vsnm_pkg::CLS_SURFACE);
                we2 = r_sg && (s_rd != vsnm_pkg::CLS_SURFACE);
            end
            default: ;
        endcase
    end

    logic acc;
    assign acc  = start && !busy;
    assign busy = (r_state != ST_IDLE);

    logic row_end;
    assign row_end = (s_rd == vsnm_pkg::CLS_SURFACE) || (r_t == sn - 1'b1);

    logic [1:0] q_rd;
    logic       q_live;
    assign q_rd   = r_q_g2 ? rd2 : rd1;
    assign q_live = r_q_in && (q_rd != vsnm_pkg::CLS_OUTER);

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_init  <= 1'b1;
            r_func  <= vsnm_pkg::FN_CLEAR;
            r_q_v   <= 1'b0;
        end else begin
            r_q_v <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (acc) begin
                    r_func <= i_func;
                    r_sel  <= i_grid_sel;
                    r_ax <= CW'(i_a_x); r_ay <= CW'(i_a_y); r_az <= CW'(i_a_z);
                    r_bx <= CW'(i_b_x); r_by <= CW'(i_b_y); r_bz <= CW'(i_b_z);
                    r_step <= '0; r_cls <= '0; r_same <= '0; r_other <= '0;
                    r_clr <= '0;
                    r_sg <= 1'b0; r_axis <= 2'd0; r_dir <= 1'b0;
                    r_u <= '0; r_v <= '0; r_t <= '0;
                    r_err <= !((CW'(i_a_x) + 5'd2 <= S1) && (CW'(i_a_y) + 5'd2 <= S1)
                            && (CW'(i_a_z) + 5'd2 <= S1) && (CW'(i_b_x) + 5'd2 <= S2)
                            && (CW'(i_b_y) + 5'd2 <= S2) && (CW'(i_b_z) + 5'd2 <= S2));
                    unique case (i_func)
                        vsnm_pkg::FN_CLEAR: r_state <= ST_CLEAR;
                        vsnm_pkg::FN_MARK:  r_state <= ST_MARK;
                        vsnm_pkg::FN_CLASS: r_state <= ST_SCAN;
                        default: begin
                            r_state <= ST_QRY;
                            r_err <= !((CW'(i_a_x) < (i_grid_sel ? S2 : S1))
                                    && (CW'(i_a_y) < (i_grid_sel ? S2 : S1))
                                    && (CW'(i_a_z) < (i_grid_sel ? S2 : S1)));
                        end
                    endcase
                end
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW2+1)'(D2 - 1)) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? ST_IDLE : ST_DONE;
                    end
                end
                ST_MARK: begin
                    r_step <= r_step + 1'b1;
                    if (r_err || r_step == 5'd15) r_state <= ST_DONE;
                end
                ST_QRY: begin
                    if (r_err) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_q_v <= (r_step <= 5'd14);
                        r_q_in <= q_in; r_q_g2 <= q_g2; r_q_step <= r_step;
                        r_step <= r_step + 1'b1;
                        if (r_step == 5'd15) r_state <= ST_DONE;
                    end
                end
                ST_SCAN: r_state <= ST_SWR;
                ST_SWR: begin
                    r_state <= ST_SCAN;
                    if (row_end) begin
                        r_t <= '0;
                        if (r_v == sn - 1'b1) begin
                            r_v <= '0;
                            if (r_u == sn - 1'b1) begin
                                r_u <= '0;
                                r_dir <= !r_dir;
                                if (r_dir) begin
                                    if (r_axis == 2'd2) begin
                                        r_axis <= 2'd0;
                                        r_sg <= 1'b1;
                                        if (r_sg) r_state <= ST_DONE;
                                    end else begin
                                        r_axis <= r_axis + 1'b1;
                                    end
                                end
                            end else begin
                                r_u <= r_u + 1'b1;
                            end
                        end else begin
                            r_v <= r_v + 1'b1;
                        end
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                    o_valid <= 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
            if (r_q_v) begin
                if (r_q_step == 5'd0) r_cls <= q_rd;
                else if (r_q_step <= 5'd6) r_same[3'(r_q_step - 5'd1)] <= q_live;
                else r_other[3'(r_q_step - 5'd7)] <= q_live;
            end
        end
    end

    logic q_ok;
    assign q_ok = (r_func == vsnm_pkg::FN_QUERY) && !r_err;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            o_point_class <= q_ok ? r_cls : 2'd0;
            o_same_mask   <= q_ok ? r_same : 6'd0;
            o_other_mask  <= q_ok ? r_other : 8'd0;
            o_is_static   <= q_ok && (r_same == 6'd0) && (r_other == 8'd0);
            o_error       <= ((r_func == vsnm_pkg::FN_QUERY) || (r_func == vsnm_pkg::FN_MARK))
                             && r_err;
        end
    end

    `VS_ASSERT_NXT(a_done_strobe, i_clk, i_rst_n, r_state == ST_DONE, o_valid && !busy)
    `VS_ASSERT_IMP(a_no_dbl_write, i_clk, i_rst_n, we1 && we2, r_state == ST_CLEAR)
    `VS_ASSERT_IMP(a_static_clean, i_clk, i_rst_n, o_valid && o_is_static,
                   o_same_mask == 6'd0 && o_other_mask == 8'd0 && !o_error)
endmodule

// ===== verif/voxel_shell_neighbour_masks_core_test.sv =====
// Self-checking testbench for the voxel shell core: clear, mark, classify and query commands
// against a behavioural copy of both class grids. Depends on vsnm_pkg and the core RTL.
`timescale 1ns / 1ps
module voxel_shell_neighbour_masks_core_test;

    localparam int N1 = 8;
    localparam int N2 = N1 + 1;
    localparam int N_ITEMS = 850;
    localparam int CYCLE_LIMIT = 8000000;

    typedef struct {
        vsnm_pkg::t_func func;
        logic       sel;
        logic [3:0] ax, ay, az, bx, by, bz;
    } t_cmd;

    typedef struct {
        logic [1:0] cls;
        logic [5:0] same;
        logic [7:0] other;
        logic       stat;
        logic       err;
    } t_answer;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_func;
    logic       i_grid_sel;
    logic [3:0] i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z;
    logic       o_valid;
    logic [1:0] o_point_class;
    logic [5:0] o_same_mask;
    logic [7:0] o_other_mask;
    logic       o_is_static;
    logic       o_error;

    voxel_shell_neighbour_masks_core #(.GRID_WIDTH(N1)) i_dut (.*);

    // Grid 0 is the first grid (side N1), grid 1 the offset grid (side N2).
    logic [1:0] shadow_grid [2][N2*N2*N2];
    t_cmd       cmd_queue[$];
    t_answer    answer_queue[$];
    t_cmd       cmd_on_bus;
    int         burst_left;
    int         gap_left;
    int         mismatches;
    int         cycles;
    int         classify_count;

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = 1'b1;
            #2 i_clk = 1'b0;
        end
    end

    function automatic int side_of(int id);
        return id ? N2 : N1;
    endfunction

    function automatic int vox_addr(int n, int x, int y, int z);
        return (z * n + y) * n + x;
    endfunction

    function automatic logic live_at(int id, int x, int y, int z);
        int n;
        n = side_of(id);
        if (x < 0 || y < 0 || z < 0 || x >= n || y >= n || z >= n) return 1'b0;
        return shadow_grid[id][vox_addr(n, x, y, z)] != vsnm_pkg::CLS_OUTER;
    endfunction

    function automatic void clear_grids();
        for (int id = 0; id < 2; id++)
            for (int i = 0; i < N2*N2*N2; i++) shadow_grid[id][i] = vsnm_pkg::CLS_INNER;
    endfunction

    function automatic void shell_walk(int id);
        int n, s, s1, s2, base, pos, idx;
        int strides[3];
        n = side_of(id);
        strides[0] = 1;
        strides[1] = n;
        strides[2] = n * n;
        for (int axis = 0; axis < 3; axis++) begin
            s  = strides[axis];
            s1 = strides[(axis + 1) % 3];
            s2 = strides[(axis + 2) % 3];
            for (int dir = 0; dir < 2; dir++)
                for (int u = 0; u < n; u++)
                    for (int v = 0; v < n; v++) begin
                        base = u * s1 + v * s2;
                        for (int t = 0; t < n; t++) begin
                            pos = dir ? (n - 1 - t) : t;
                            idx = base + pos * s;
                            if (shadow_grid[id][idx] == vsnm_pkg::CLS_SURFACE) break;
                            shadow_grid[id][idx] = vsnm_pkg::CLS_OUTER;
                        end
                    end
        end
    endfunction

    function automatic void mark_corners(int id, int x, int y, int z);
        for (int c = 0; c < 8; c++)
            shadow_grid[id][vox_addr(side_of(id), x + (c & 1), y + ((c >> 1) & 1),
                                     z + ((c >> 2) & 1))] = vsnm_pkg::CLS_SURFACE;
    endfunction

    function automatic t_answer shell_answer(t_cmd c);
        t_answer a;
        int n, g, o, x, y, z, off;
        a = '{cls: 2'd0, same: 6'd0, other: 8'd0, stat: 1'b0, err: 1'b0};
        x = c.ax;
        y = c.ay;
        z = c.az;
        case (c.func)
            vsnm_pkg::FN_CLEAR: clear_grids();
            vsnm_pkg::FN_MARK: begin
                if (c.ax <= N1 - 2 && c.ay <= N1 - 2 && c.az <= N1 - 2 &&
                    c.bx <= N2 - 2 && c.by <= N2 - 2 && c.bz <= N2 - 2) begin
                    mark_corners(0, c.ax, c.ay, c.az);
                    mark_corners(1, c.bx, c.by, c.bz);
                end else begin
                    a.err = 1'b1;
                end
            end
            vsnm_pkg::FN_CLASS: begin
                shell_walk(0);
                shell_walk(1);
            end
            default: begin
                g = c.sel ? 1 : 0;
                o = 1 - g;
                n = side_of(g);
                off = c.sel ? -1 : 0;
                if (x >= n || y >= n || z >= n) begin
                    a.err = 1'b1;
                end else begin
                    a.cls = shadow_grid[g][vox_addr(n, x, y, z)];
                    a.same[0] = live_at(g, x - 1, y, z);
                    a.same[1] = live_at(g, x + 1, y, z);
                    a.same[2] = live_at(g, x, y - 1, z);
                    a.same[3] = live_at(g, x, y + 1, z);
                    a.same[4] = live_at(g, x, y, z - 1);
                    a.same[5] = live_at(g, x, y, z + 1);
                    for (int k = 0; k < 8; k++)
                        a.other[k] = live_at(o, x + (k & 1) + off, y + ((k >> 1) & 1) + off,
                                             z + ((k >> 2) & 1) + off);
                    a.stat = (a.same == 6'd0) && (a.other == 8'd0);
                end
            end
        endcase
        return a;
    endfunction

    task automatic push_cmd(vsnm_pkg::t_func f, int sel, int ax, int ay, int az,
                            int bx, int by, int bz);
        t_cmd c;
        c.func = f;
        c.sel = 1'(sel);
        c.ax = 4'(ax);
        c.ay = 4'(ay);
        c.az = 4'(az);
        c.bx = 4'(bx);
        c.by = 4'(by);
        c.bz = 4'(bz);
        if (f == vsnm_pkg::FN_CLASS) classify_count++;
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    task automatic push_random(vsnm_pkg::t_func f);
        push_cmd(f, $urandom_range(1, 0), $urandom_range(15, 0), $urandom_range(15, 0),
                 $urandom_range(15, 0), $urandom_range(15, 0), $urandom_range(15, 0),
                 $urandom_range(15, 0));
    endtask

    // A clear, then a clustered group of marks, a classify and queries around the cluster,
    // so that enclosed inner points survive the scans now and then.
    task automatic push_shape();
        int org, span, nm, nq, ax, ay, az;
        org = $urandom_range(3, 0);
        span = $urandom_range(4, 2);
        nm = $urandom_range(40, 6);
        nq = $urandom_range(40, 10);
        push_cmd(vsnm_pkg::FN_CLEAR, $urandom_range(1, 0), $urandom_range(15, 0),
                 $urandom_range(15, 0), $urandom_range(15, 0), 0, 0, 0);
        for (int i = 0; i < nm; i++) begin
            ax = org + $urandom_range(span, 0);
            ay = org + $urandom_range(span, 0);
            az = org + $urandom_range(span, 0);
            if ($urandom_range(15, 0) == 0)
                push_random(vsnm_pkg::FN_MARK);
            else
                push_cmd(vsnm_pkg::FN_MARK, $urandom_range(1, 0), ax > 6 ? 6 : ax,
                         ay > 6 ? 6 : ay, az > 6 ? 6 : az, ax + $urandom_range(1, 0),
                         ay + $urandom_range(1, 0), az + $urandom_range(1, 0));
        end
        push_cmd(vsnm_pkg::FN_CLASS, $urandom_range(1, 0), 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < nq; i++) begin
            if ($urandom_range(9, 0) == 0)
                push_random(vsnm_pkg::FN_QUERY);
            else
                push_cmd(vsnm_pkg::FN_QUERY, $urandom_range(1, 0), $urandom_range(9, 0),
                         $urandom_range(9, 0), $urandom_range(9, 0), $urandom_range(15, 0),
                         $urandom_range(15, 0), $urandom_range(15, 0));
        end
    endtask

    // Sender: bursts of commands separated by random gaps.
    always @(posedge i_clk) begin
        t_cmd   nxt;
        logic   take;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            take = !start || !busy;
            if (start && !busy)
                answer_queue.insert(answer_queue.size(), shell_answer(cmd_on_bus));
            if (take) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    nxt = cmd_queue.pop_front();
                    cmd_on_bus <= nxt;
                    i_func     <= nxt.func;
                    i_grid_sel <= nxt.sel;
                    i_a_x      <= nxt.ax;
                    i_a_y      <= nxt.ay;
                    i_a_z      <= nxt.az;
                    i_b_x      <= nxt.bx;
                    i_b_y      <= nxt.by;
                    i_b_z      <= nxt.bz;
                    start      <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(12, 0);
                        gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(25, 0);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result checker: every strobe is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            if (answer_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
            end else begin
                want = answer_queue.pop_front();
                if (o_point_class !== want.cls || o_same_mask !== want.same ||
                    o_other_mask !== want.other || o_is_static !== want.stat ||
                    o_error !== want.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at cycle %0d: exp cls %0d same %h other %h st %b",
                                 cycles, want.cls, want.same, want.other, want.stat,
                                 " err %b, got cls %0d same %h other %h st %b err %b",
                                 want.err, o_point_class, o_same_mask, o_other_mask,
                                 o_is_static, o_error);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("voxel_shell_neighbour_masks_core_test NOT OK");
            $finish;
        end
    end

    initial begin
        start = 1'b0;
        i_func = vsnm_pkg::FN_CLEAR;
        i_grid_sel = 1'b0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z} = '0;
        i_rst_n = 1'b0;
        burst_left = 0;
        gap_left = 0;
        mismatches = 0;
        cycles = 0;
        classify_count = 0;
        clear_grids();

        // Directed: corner cells, range limits, both grids' edges, overwrite of outer.
        push_cmd(vsnm_pkg::FN_QUERY, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_MARK, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_MARK, 1, 6, 6, 6, 7, 7, 7);
        push_cmd(vsnm_pkg::FN_MARK, 0, 7, 0, 0, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_MARK, 0, 0, 0, 0, 0, 8, 0);
        push_cmd(vsnm_pkg::FN_MARK, 1, 15, 15, 15, 15, 15, 15);
        push_cmd(vsnm_pkg::FN_QUERY, 0, 0, 0, 0, 15, 15, 15);
        push_cmd(vsnm_pkg::FN_QUERY, 0, 7, 7, 7, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_QUERY, 1, 0, 0, 0, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_QUERY, 1, 8, 8, 8, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_QUERY, 0, 8, 0, 0, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_QUERY, 1, 0, 9, 0, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_QUERY, 1, 15, 15, 15, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_CLASS, 1, 15, 15, 15, 15, 15, 15);
        push_cmd(vsnm_pkg::FN_QUERY, 0, 3, 3, 3, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_QUERY, 1, 1, 1, 1, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_MARK, 0, 3, 3, 3, 3, 3, 3);
        push_cmd(vsnm_pkg::FN_QUERY, 0, 3, 3, 3, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_QUERY, 1, 4, 4, 4, 0, 0, 0);
        push_cmd(vsnm_pkg::FN_CLEAR, 1, 15, 15, 15, 15, 15, 15);
        push_cmd(vsnm_pkg::FN_QUERY, 1, 8, 8, 8, 0, 0, 0);

        while (cmd_queue.size() < N_ITEMS) begin
            if ($urandom_range(9, 0) < 7)
                push_shape();
            else
                for (int i = 0; i < 15; i++) begin
                    case ($urandom_range(19, 0))
                        0: push_random(vsnm_pkg::FN_CLEAR);
                        1: push_random(classify_count < 30 ? vsnm_pkg::FN_CLASS
                                                           : vsnm_pkg::FN_QUERY);
                        2, 3, 4, 5, 6, 7, 8: push_random(vsnm_pkg::FN_MARK);
                        default: push_random(vsnm_pkg::FN_QUERY);
                    endcase
                end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_queue.size() > 0 || start || answer_queue.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && answer_queue.size() == 0)
            $display("voxel_shell_neighbour_masks_core_test OK");
        else
            $display("voxel_shell_neighbour_masks_core_test NOT OK");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/vsnm_pkg.sv
hw/rtl/vsnm_grid_mem.sv
hw/rtl/voxel_shell_neighbour_masks_core.sv
verif/voxel_shell_neighbour_masks_core_test.sv
